@@ src/ems2cal_pkg.sv @@
package ems2cal_pkg;

  // Pipeline depth from the input register to the output register
  localparam int unsigned NumStages = 9;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusBad   = 2'd2
  } status_e;

  // Last count that still converts: 2100-01-01 00:00:00.000
  localparam logic [47:0] LastValidMs = 48'd4102444800000;

  // A day is 84375 * 1024 ms, so days = (ms >> 10) / 84375
  localparam logic [16:0] DayUnits    = 17'd84375;
  localparam logic [31:0] DayRecip    = 32'd3335999724;  // ceil(2^48 / 84375)
  localparam int unsigned DayShift    = 48;

  localparam logic [19:0] DaysToEpoch = 20'd719468;
  localparam logic [19:0] EraFourBase = 20'd584388;      // 4 * 146097
  localparam logic [19:0] EraFiveBase = 20'd730485;      // 5 * 146097

  // Reciprocals, each exact over the value range it sees
  localparam logic [27:0] SecRecip    = 28'd137438954;   // ceil(2^37 / 1000)
  localparam logic [17:0] HourRecip   = 18'd149131;      // ceil(2^29 / 3600)
  localparam logic [12:0] MinRecip    = 13'd4370;        // ceil(2^18 / 60)
  localparam logic [18:0] Q1460Recip  = 19'd367720;      // ceil(2^29 / 1460)
  localparam logic [18:0] YearRecip   = 19'd367720;      // ceil(2^27 / 365)
  localparam logic [11:0] MonthRecip  = 12'd3427;        // ceil(2^19 / 153)

  localparam logic [9:0]  MsPerSec    = 10'd1000;
  localparam logic [11:0] SecPerHour  = 12'd3600;
  localparam logic [5:0]  SecPerMin   = 6'd60;
  localparam logic [8:0]  DaysPerYear = 9'd365;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } tod_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // Days from March 1 to the first of month index mp (March is zero)
  function automatic logic [8:0] days_before_month(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ src/ems2cal_split.sv @@
module ems2cal_split import ems2cal_pkg::*; (
  input  logic        clk_i,
  input  logic [2:0]  en_i,
  input  logic [47:0] epoch_millis_i,
  output logic [26:0] msd_o,
  output logic [17:0] doe_o,
  output logic        era5_o
);

  logic [31:0] x1_q, x2_q;
  logic [9:0]  lo1_q, lo2_q;
  logic [15:0] days2_q;
  logic [26:0] msd3_q;
  logic [17:0] doe3_q;
  logic        era3_q;

  logic [63:0] day_prod;
  logic [31:0] day_ms;
  logic [31:0] rday;
  logic [19:0] z;
  logic        era5;
  logic [19:0] doe_full;

  assign day_prod = 64'(x1_q) * 64'(DayRecip);

  always_comb begin
    day_ms   = 32'(days2_q) * 32'(DayUnits);
    rday     = x2_q - day_ms;
    z        = 20'(days2_q) + DaysToEpoch;
    era5     = (z >= EraFiveBase);
    doe_full = z - (era5 ? EraFiveBase : EraFourBase);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x1_q  <= epoch_millis_i[41:10];
      lo1_q <= epoch_millis_i[9:0];
    end
    if (en_i[1]) begin
      days2_q <= day_prod[DayShift+15:DayShift];
      x2_q    <= x1_q;
      lo2_q   <= lo1_q;
    end
    if (en_i[2]) begin
      msd3_q <= {rday[16:0], lo2_q};
      doe3_q <= doe_full[17:0];
      era3_q <= era5;
    end
  end

  assign msd_o  = msd3_q;
  assign doe_o  = doe3_q;
  assign era5_o = era3_q;

endmodule

@@ src/ems2cal_tod.sv @@
module ems2cal_tod import ems2cal_pkg::*; (
  input  logic        clk_i,
  input  logic [4:0]  en_i,
  input  logic [26:0] msd_i,
  output tod_t        tod_o
);

  logic [16:0] sec4_q, sec5_q;
  logic [26:0] msd4_q;
  logic [9:0]  frac5_q, frac6_q, frac7_q, frac8_q;
  logic [4:0]  hh5_q, hh6_q, hh7_q, hh8_q;
  logic [11:0] rem6_q, rem7_q;
  logic [5:0]  mi7_q, mi8_q;
  logic [5:0]  ss8_q;

  logic [54:0] sec_prod;
  logic [26:0] sec_ms;
  logic [34:0] hh_prod;
  logic [16:0] hh_sec;
  logic [24:0] mi_prod;
  logic [11:0] mi_sec;
  logic [26:0] frac_full;
  logic [16:0] rem_full;
  logic [11:0] ss_full;

  always_comb begin
    sec_prod  = 55'(msd_i) * 55'(SecRecip);
    sec_ms    = 27'(sec4_q) * 27'(MsPerSec);
    frac_full = msd4_q - sec_ms;
    hh_prod   = 35'(sec4_q) * 35'(HourRecip);
    hh_sec    = 17'(hh5_q) * 17'(SecPerHour);
    rem_full  = sec5_q - hh_sec;
    mi_prod   = 25'(rem6_q) * 25'(MinRecip);
    mi_sec    = 12'(mi7_q) * 12'(SecPerMin);
    ss_full   = rem7_q - mi_sec;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sec4_q <= sec_prod[53:37];
      msd4_q <= msd_i;
    end
    if (en_i[1]) begin
      frac5_q <= frac_full[9:0];
      hh5_q   <= hh_prod[33:29];
      sec5_q  <= sec4_q;
    end
    if (en_i[2]) begin
      rem6_q  <= rem_full[11:0];
      hh6_q   <= hh5_q;
      frac6_q <= frac5_q;
    end
    if (en_i[3]) begin
      mi7_q   <= mi_prod[23:18];
      rem7_q  <= rem6_q;
      hh7_q   <= hh6_q;
      frac7_q <= frac6_q;
    end
    if (en_i[4]) begin
      ss8_q   <= ss_full[5:0];
      mi8_q   <= mi7_q;
      hh8_q   <= hh7_q;
      frac8_q <= frac7_q;
    end
  end

  assign tod_o = '{hour: hh8_q, minute: mi8_q, second: ss8_q, millisecond: frac8_q};

endmodule

@@ src/ems2cal_date.sv @@
module ems2cal_date import ems2cal_pkg::*; (
  input  logic        clk_i,
  input  logic [4:0]  en_i,
  input  logic [17:0] doe_i,
  input  logic        era5_i,
  output date_t       date_o
);

  logic [17:0] doe4_q, doe5_q, doe6_q;
  logic        era4_q, era5_q, era6_q, era7_q, era8_q;
  logic [6:0]  q1460_4_q;
  logic [2:0]  c36524_4_q;
  logic        c146096_4_q;
  logic [17:0] n5_q;
  logic [8:0]  yoe6_q, yoe7_q, yoe8_q;
  logic [8:0]  doy7_q, doy8_q;
  logic [3:0]  mp8_q;

  logic [36:0] q1460_prod;
  logic [2:0]  c36524;
  logic [17:0] n_full;
  logic [36:0] yoe_prod;
  logic [1:0]  c100;
  logic [17:0] ydays;
  logic [17:0] doy_full;
  logic [10:0] mnum;
  logic [22:0] mp_prod;
  logic [8:0]  dbm;
  logic [8:0]  dy_full;
  logic [3:0]  mo;
  logic [11:0] yr;

  always_comb begin
    q1460_prod = 37'(doe_i) * 37'(Q1460Recip);
    c36524     = 3'(doe_i >= 18'd36524) + 3'(doe_i >= 18'd73048)
               + 3'(doe_i >= 18'd109572) + 3'(doe_i >= 18'd146096);
    n_full     = doe4_q - 18'(q1460_4_q) + 18'(c36524_4_q) - 18'(c146096_4_q);
    yoe_prod   = 37'(n5_q) * 37'(YearRecip);
    c100       = 2'(yoe6_q >= 9'd100) + 2'(yoe6_q >= 9'd200) + 2'(yoe6_q >= 9'd300);
    ydays      = 18'(yoe6_q) * 18'(DaysPerYear) + 18'(yoe6_q[8:2]) - 18'(c100);
    doy_full   = doe6_q - ydays;
    mnum       = 11'(doy7_q) * 11'd5 + 11'd2;
    mp_prod    = 23'(mnum) * 23'(MonthRecip);
    // March-based month index back to a calendar month and year
    dbm        = days_before_month(mp8_q);
    dy_full    = doy8_q - dbm + 9'd1;
    mo         = (mp8_q < 4'd10) ? mp8_q + 4'd3 : mp8_q - 4'd9;
    yr         = 12'(yoe8_q) + (era8_q ? 12'd2000 : 12'd1600) + 12'(mo <= 4'd2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      q1460_4_q   <= q1460_prod[35:29];
      c36524_4_q  <= c36524;
      c146096_4_q <= (doe_i == 18'd146096);
      doe4_q      <= doe_i;
      era4_q      <= era5_i;
    end
    if (en_i[1]) begin
      n5_q   <= n_full;
      doe5_q <= doe4_q;
      era5_q <= era4_q;
    end
    if (en_i[2]) begin
      yoe6_q <= yoe_prod[35:27];
      doe6_q <= doe5_q;
      era6_q <= era5_q;
    end
    if (en_i[3]) begin
      doy7_q <= doy_full[8:0];
      yoe7_q <= yoe6_q;
      era7_q <= era6_q;
    end
    if (en_i[4]) begin
      mp8_q  <= mp_prod[22:19];
      doy8_q <= doy7_q;
      yoe8_q <= yoe7_q;
      era8_q <= era7_q;
    end
  end

  assign date_o = '{year: yr, month: mo, day: dy_full[4:0]};

endmodule

@@ src/epoch_ms_to_calendar_datetime.sv @@
// Epoch milliseconds to Gregorian date and time of day.
//
// Input channel: in_valid_i / in_ready_o carry epoch_millis_i, a count of
// milliseconds since 1970-01-01 00:00:00.000 UTC. Output channel:
// out_valid_o / out_ready_i carry one result per input: status_o, year_o,
// month_o, day_of_month_o, hour_o, minute_o, second_o, millisecond_o.
// A zero count reports empty and a count past 2100-01-01 reports bad; in
// both cases every date and time field is zero.
//
// Throughput: one transfer per cycle on each side while out_ready_i stays
// high. Each result passes through the nine register stages: the input
// transfer loads the first and the result moves on one stage whenever
// the next stage loads (about one constant multiply or subtract per stage
// on each of the date and time-of-day paths).
//
// Every stage holds its own valid bit. When out_ready_i is low, the output
// register holds its result and the stages behind it keep filling any
// empty slots, so in_ready_o stays high until the whole chain is full.
// Reset empties all stages; no result is pending after reset.
module epoch_ms_to_calendar_datetime import ems2cal_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [47:0] epoch_millis_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [9:0]  millisecond_o
);

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] en;

  // Status rides alongside the data through the first eight stages
  status_e st_q [NumStages-1];
  status_e st_in;

  logic [26:0] msd;
  logic [17:0] doe;
  logic        era5;
  tod_t        tod;
  date_t       date;

  status_e     status_q;
  tod_t        tod_q;
  date_t       date_q;

  // A stage loads when it is empty or when the stage after it loads
  always_comb begin
    en[NumStages-1] = ~valid_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Classify the count on entry
  always_comb begin
    if (epoch_millis_i == '0) begin
      st_in = StatusEmpty;
    end else if (epoch_millis_i > LastValidMs) begin
      st_in = StatusBad;
    end else begin
      st_in = StatusOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      st_q[0] <= st_in;
    end
    for (int k = 1; k < NumStages - 1; k++) begin
      if (en[k]) begin
        st_q[k] <= st_q[k-1];
      end
    end
  end

  // Stages 1-3: split into day number and millisecond of day
  ems2cal_split u_split (
    .clk_i          (clk_i),
    .en_i           (en[2:0]),
    .epoch_millis_i (epoch_millis_i),
    .msd_o          (msd),
    .doe_o          (doe),
    .era5_o         (era5)
  );

  // Stages 4-8: time of day
  ems2cal_tod u_tod (
    .clk_i (clk_i),
    .en_i  (en[7:3]),
    .msd_i (msd),
    .tod_o (tod)
  );

  // Stages 4-8: civil date within the era
  ems2cal_date u_date (
    .clk_i  (clk_i),
    .en_i   (en[7:3]),
    .doe_i  (doe),
    .era5_i (era5),
    .date_o (date)
  );

  // Output register: drop the fields to zero unless the date is valid
  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      status_q <= st_q[NumStages-2];
      if (st_q[NumStages-2] == StatusOk) begin
        tod_q  <= tod;
        date_q <= date;
      end else begin
        tod_q  <= '0;
        date_q <= '0;
      end
    end
  end

  assign in_ready_o     = en[0];
  assign out_valid_o    = valid_q[NumStages-1];
  assign status_o       = status_q;
  assign year_o         = date_q.year;
  assign month_o        = date_q.month;
  assign day_of_month_o = date_q.day;
  assign hour_o         = tod_q.hour;
  assign minute_o       = tod_q.minute;
  assign second_o       = tod_q.second;
  assign millisecond_o  = tod_q.millisecond;

endmodule

@@ test/epoch_ms_to_calendar_datetime_tb.sv @@
`timescale 1ns / 100ps

module epoch_ms_to_calendar_datetime_tb;

  import ems2cal_pkg::status_e;
  import ems2cal_pkg::StatusOk;
  import ems2cal_pkg::StatusEmpty;
  import ems2cal_pkg::StatusBad;
  import ems2cal_pkg::NumStages;
  import ems2cal_pkg::LastValidMs;

  // Calendar arithmetic constants for the predictor
  localparam longint unsigned MsPerDay    = 64'd86400000;
  localparam longint unsigned MarchShift  = 64'd719468;   // days from 0000-03-01 to 1970-01-01
  localparam longint unsigned EraDays     = 64'd146097;   // days in 400 Gregorian years
  localparam longint unsigned LastDay     = 64'd47482;    // day number of 2100-01-01

  localparam int unsigned RandomItems = 750;
  localparam int unsigned IdlePercent = 30;
  localparam int unsigned LongHold    = 64;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct {
    status_e     status;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } datetime_t;

  // Expected datetimes, one per accepted timestamp, oldest first
  class datetime_scoreboard;
    datetime_t   expected_dates[$];
    int unsigned mismatches = 0;

    // Civil-from-days over 400-year eras, March as month zero
    function datetime_t civil_datetime(logic [47:0] ms);
      longint unsigned m, days, sod, z, era, doe, yoe, doy, mp, mo;
      datetime_t r;
      m = 64'(ms);
      r.status       = StatusOk;
      r.year         = '0;
      r.month        = '0;
      r.day_of_month = '0;
      r.hour         = '0;
      r.minute       = '0;
      r.second       = '0;
      r.millisecond  = '0;
      if (m == 0) begin
        r.status = StatusEmpty;
        return r;
      end
      if (m > LastValidMs) begin
        r.status = StatusBad;
        return r;
      end
      days = m / MsPerDay;
      sod  = (m % MsPerDay) / 1000;
      z    = days + MarchShift;
      era  = z / EraDays;
      doe  = z - era * EraDays;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      mo   = (mp < 10) ? mp + 3 : mp - 9;
      r.year         = 12'(yoe + era * 400 + ((mo <= 2) ? 1 : 0));
      r.month        = 4'(mo);
      r.day_of_month = 5'(doy - (153 * mp + 2) / 5 + 1);
      r.hour         = 5'(sod / 3600);
      r.minute       = 6'((sod % 3600) / 60);
      r.second       = 6'(sod % 60);
      r.millisecond  = 10'(m % 1000);
      return r;
    endfunction

    function void note_timestamp(logic [47:0] ms);
      expected_dates.push_back(civil_datetime(ms));
    endfunction

    function void check_field(string name, logic [11:0] exp_val, logic [11:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_datetime(datetime_t act);
      datetime_t exp;
      if (expected_dates.size() == 0) begin
        $error("result transfer with no timestamp outstanding");
        mismatches++;
        return;
      end
      exp = expected_dates.pop_front();
      check_field("status", 12'(exp.status), 12'(act.status));
      check_field("year", exp.year, act.year);
      check_field("month", 12'(exp.month), 12'(act.month));
      check_field("day_of_month", 12'(exp.day_of_month), 12'(act.day_of_month));
      check_field("hour", 12'(exp.hour), 12'(act.hour));
      check_field("minute", 12'(exp.minute), 12'(act.minute));
      check_field("second", 12'(exp.second), 12'(act.second));
      check_field("millisecond", 12'(exp.millisecond), 12'(act.millisecond));
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [47:0] epoch_millis_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  logic [9:0]  millisecond_o;

  datetime_scoreboard sb;

  // Calm stretch: neither side idles at random; hold request: receiver
  // drops ready while the sender keeps offering
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int unsigned cycles = 0;

  // Edges of the range, calendar corners and leap days
  logic [47:0] directed_ms [$] = '{
    48'd0,                // empty
    48'd1,                // first valid millisecond
    48'd999,
    48'd1000,
    48'd86399999,         // 1970-01-01 23:59:59.999
    48'd86400000,         // 1970-01-02
    48'd68169600000,      // 1972-02-29
    48'd86445296789,      // mid-day with every time field nonzero
    48'd946684799999,     // 1999-12-31 23:59:59.999
    48'd951782400000,     // 2000-02-29, century leap year
    48'd951868800000,     // 2000-03-01, start of a new era
    48'd978307199999,     // 2000-12-31, day 366
    48'd3981312000000,    // 2096-02-29, last leap day in range
    48'd4102444799999,    // last millisecond of 2099
    48'd4102444800000,    // 2100-01-01, last valid count
    48'd4102444800001,    // first bad count
    48'h800000000000,
    48'hFFFFFFFFFFFF
  };

  epoch_ms_to_calendar_datetime i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .epoch_millis_i (epoch_millis_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o),
    .millisecond_o  (millisecond_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hold reset, then release it away from the active edge
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Offer one timestamp and hold it until the input transfer happens.
  // Valid stays high on return so back-to-back items need no gap.
  task automatic offer_timestamp(input logic [47:0] ms);
    in_valid_i     <= 1'b1;
    epoch_millis_i <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_timestamp(ms);
  endtask

  // Drop valid for the given gap; scramble the payload to show it is ignored
  task automatic pause_sender(input int unsigned gap);
    in_valid_i     <= 1'b0;
    epoch_millis_i <= 48'({$urandom, $urandom});
    repeat (gap) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [63:0] wide;
    logic [47:0] ms;
    int unsigned pick;
    sb = new();
    @(posedge rst_ni);
    @(posedge clk_i);

    foreach (directed_ms[k]) begin
      if ($urandom_range(99) < IdlePercent) pause_sender($urandom_range(1, 2));
      offer_timestamp(directed_ms[k]);
    end

    for (int n = 0; n < RandomItems; n++) begin
      // Run a stretch without idling and stall the receiver inside it
      calm = (n >= 150 && n < 350);
      if (n == 200) hold_request = 1'b1;

      pick = $urandom_range(99);
      wide = {$urandom, $urandom};
      if (pick < 55) begin
        // anywhere in the valid range
        ms = 48'(wide % 64'(LastValidMs)) + 48'd1;
      end else if (pick < 72) begin
        // day boundaries: midnight, last millisecond, or random time
        ms = 48'($urandom_range(0, 32'(LastDay))) * 48'(MsPerDay);
        case ($urandom_range(2))
          0:       ms = ms;
          1:       ms = ms + 48'(MsPerDay - 1);
          default: ms = ms + 48'($urandom_range(0, 32'(MsPerDay - 1)));
        endcase
      end else if (pick < 82) begin
        // around the upper edge of the range
        ms = LastValidMs - 48'd500 + 48'($urandom_range(0, 1000));
      end else if (pick < 97) begin
        // any 48-bit pattern, mostly out of range
        ms = wide[47:0];
      end else begin
        ms = '0;
      end

      if (!calm && $urandom_range(99) < IdlePercent) pause_sender($urandom_range(1, 2));
      offer_timestamp(ms);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then watch for stray results through the pipeline depth
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (NumStages + 4) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Check every result transfer, then pick ready for the next cycle
  initial begin : result_sink
    datetime_t seen;
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        seen.status       = status_e'(status_o);
        seen.year         = year_o;
        seen.month        = month_o;
        seen.day_of_month = day_of_month_o;
        seen.hour         = hour_o;
        seen.minute       = minute_o;
        seen.second       = second_o;
        seen.millisecond  = millisecond_o;
        sb.check_datetime(seen);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_request) begin
        // long hold-off so the pipeline fills and backs up the input
        hold_request = 1'b0;
        hold_left    = LongHold - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
src/ems2cal_pkg.sv
src/ems2cal_split.sv
src/ems2cal_tod.sv
src/ems2cal_date.sv
src/epoch_ms_to_calendar_datetime.sv
test/epoch_ms_to_calendar_datetime_tb.sv
